// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the hole-fill RTL.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger implies outcome at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/thfna_pkg.sv -----
// Types, constants and divide helpers for the hole-fill block.
// No dependencies; imported by every file except assert_macros.svh.
package thfna_pkg;

	localparam int MAX_SIZE    = 1024;
	localparam int COL_W       = $clog2(MAX_SIZE);
	localparam int ROW_W       = COL_W + 1;
	localparam int SIZE_W      = 11;
	localparam int CH_W        = 8;
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_OUTPUT = 1'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET   = 11'd1024;
	localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'd255;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// floor(v/3) = (v * 2731) >> 13, exact for v < 8192
	localparam int RECIP3       = 2731;
	localparam int RECIP3_SHIFT = 13;
	localparam int PROD_W       = RECIP3_SHIFT + SUM_W;

	typedef struct packed {
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] r;
	} rgb_t;

	typedef struct packed {
		logic fault;
		logic filled;
		rgb_t rgb;
	} entry_t;

	typedef struct packed {
		rgb_t rgb;
		logic valid;
	} nbr_t;

	typedef struct packed {
		entry_t center;
		nbr_t   left;
		nbr_t   right;
		nbr_t   up;
		nbr_t   down;
		logic   last;
	} job_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              color;
		logic              restart;
	} cfg_t;

	function automatic logic [ROW_W-1:0] side_of(input logic [SIZE_W-1:0] sz);
		logic [ROW_W-1:0] s;
		if (sz == '0) begin
			s = ROW_W'(1);
		end else if (int'(sz) > MAX_SIZE) begin
			s = ROW_W'(MAX_SIZE);
		end else begin
			s = ROW_W'(sz);
		end
		return s;
	endfunction

	function automatic logic [SUM_W-1:0] div3(input logic [SUM_W-1:0] v);
		logic [PROD_W-1:0] p;
		p = PROD_W'(v) * PROD_W'(RECIP3);
		return p[RECIP3_SHIFT +: SUM_W];
	endfunction

	// floor(v/n) for n in 1..4, zero when no contributor
	function automatic logic [SUM_W-1:0] div_n(input logic [SUM_W-1:0] v,
		input logic [CNT_W-1:0] n);
		logic [SUM_W-1:0] q;
		case (n)
			3'd1: q = v;
			3'd2: q = v >> 1;
			3'd3: q = div3(v);
			3'd4: q = v >> 2;
			default: q = '0;
		endcase
		return q;
	endfunction

endpackage

// ----- rtl/thfna_channels.sv -----
// Valid/ready channel interfaces for pixel items and result items.
// Depends on thfna_pkg.
interface thfna_pixel_if;
	import thfna_pkg::*;
	logic            valid;
	logic            ready;
	logic            mode;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] alpha;
	modport source(output valid, mode, red, green, blue, alpha, input ready);
	modport sink(input valid, mode, red, green, blue, alpha, output ready);
endinterface

interface thfna_result_if;
	import thfna_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic            frame_last;
	logic            fault;
	modport source(output valid, out_red, out_green, out_blue, frame_last, fault,
		input ready);
	modport sink(input valid, out_red, out_green, out_blue, frame_last, fault,
		output ready);
endinterface

// ----- rtl/texture_hole_fill_neighbour_average.sv -----
// Top level of the texture hole-fill block: configuration registers, front end,
// job queue and back end. Depends on thfna_pkg, thfna_channels and all thfna_ modules.

// Fills transparent texels of a square RGBA image streamed in raster order:
// an opaque texel passes through, a hole takes the floored mean of its filled
// left/right/up/down neighbours inside the image, or black if there are none.
// In gray mode (color_output = 0) the result is floor(R+G+B over 3n) on out_red
// with green and blue zero. Results lag the input by one row: the pixel item at
// row y emits the texel of row y-1, the first row emits nothing, and once all
// rows are in, one drain item (mode = 1) per column flushes the last row; the
// final texel carries frame_last. Drain items before the image is complete and
// pixel items while draining are swallowed without a result. fault flags alpha
// other than 0 or 255, or a hole whose RGB is not black. Writing image_size
// restarts the frame; sizes of 0 act as 1 and sizes above 1024 as 1024.
// Each item passes two front-end states (row-store read on accept, then store
// write and enqueue), so the block takes no new item until the last is written
// and queued; a result then passes the three-stage back end (s1, s2, output
// register). The two-entry job queue and the output register let input and
// output stall independently. The row stores are not cleared after reset; a
// frame can read entries never written, but no result uses their values.

module texture_hole_fill_neighbour_average (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [thfna_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thfna_pkg::SIZE_W-1:0]     cfg_data,
	thfna_pixel_if.sink                      pixel,
	thfna_result_if.source                   result
);
	import thfna_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic              color_q;
	cfg_t              cfg;
	job_t              job_in, job_out;
	logic              job_push, job_full, job_pop, job_empty;

	// user writes config only while idle, unenforced; size write also restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RESET;
			color_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_IMAGE_SIZE:   size_q  <= cfg_data;
				REG_COLOR_OUTPUT: color_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.size    = size_q;
	assign cfg.color   = color_q;
	assign cfg.restart = cfg_wen && (cfg_index == REG_IMAGE_SIZE);

	thfna_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pixel    (pixel),
		.job      (job_in),
		.job_push (job_push),
		.job_full (job_full)
	);

	thfna_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (job_in),
		.push    (job_push),
		.full    (job_full),
		.rd_data (job_out),
		.empty   (job_empty),
		.pop     (job_pop)
	);

	thfna_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.color     (cfg.color),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.result    (result)
	);
endmodule

// ----- rtl/thfna_front.sv -----
// Front end: accepts items, tracks raster position, owns both row stores,
// gathers the stencil for each result into a job. Depends on thfna_pkg, channels.
`include "assert_macros.svh"

module thfna_front (
	input  logic              clk,
	input  logic              arst_n,
	input  thfna_pkg::cfg_t   cfg,
	thfna_pixel_if.sink       pixel,
	output thfna_pkg::job_t   job,
	output logic              job_push,
	input  logic              job_full
);
	import thfna_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_WRITE = 2'b10
	} state_t;

	state_t           state_q;
	logic [COL_W-1:0] x_q;
	logic [ROW_W-1:0] y_q;
	entry_t           left_q;

	entry_t row1_mem [MAX_SIZE];
	entry_t row2_mem [MAX_SIZE];

	entry_t center_rd_q, right_rd_q, up_rd_q, down_q;
	logic   drain_q, produce_q, last_q, has_left_q, has_right_q, has_up_q;

	logic [ROW_W-1:0] side, x_ext, x_eff, x_inc;
	logic [COL_W-1:0] addr, addr_right;
	logic             accept, is_pixel, is_drain, take, fire;
	logic             has_left, has_right;
	entry_t           e;

	assign side       = side_of(cfg.size);
	assign x_ext      = ROW_W'(x_q);
	assign x_eff      = (x_ext >= side) ? '0 : x_ext;
	assign x_inc      = x_eff + ROW_W'(1);
	assign addr       = x_eff[COL_W-1:0];
	assign addr_right = x_inc[COL_W-1:0];
	assign has_left   = (x_eff != '0);
	assign has_right  = (x_inc < side);

	assign pixel.ready = (state_q == S_IDLE);
	assign accept      = pixel.valid && pixel.ready;
	assign is_pixel    = (pixel.mode == MODE_PIXEL) && (y_q < side);
	assign is_drain    = (pixel.mode == MODE_DRAIN) && (y_q >= side);
	assign take        = accept && (is_pixel || is_drain);

	always_comb begin
		e.rgb.r  = pixel.red;
		e.rgb.g  = pixel.green;
		e.rgb.b  = pixel.blue;
		e.filled = (pixel.alpha != '0);
		e.fault  = ((pixel.alpha != '0) && (pixel.alpha != ALPHA_OPAQUE))
			|| ((pixel.alpha == '0) && ((pixel.red | pixel.green | pixel.blue) != '0));
	end

	// first-row items with no result still need the store update
	assign fire     = (state_q == S_WRITE) && !(produce_q && job_full);
	assign job_push = (state_q == S_WRITE) && produce_q && !job_full;

	always_comb begin
		job.center      = center_rd_q;
		job.left.rgb    = left_q.rgb;
		job.left.valid  = has_left_q && left_q.filled;
		job.right.rgb   = right_rd_q.rgb;
		job.right.valid = has_right_q && right_rd_q.filled;
		job.up.rgb      = up_rd_q.rgb;
		job.up.valid    = has_up_q && up_rd_q.filled;
		job.down.rgb    = down_q.rgb;
		job.down.valid  = !drain_q && down_q.filled;
		job.last        = drain_q && last_q;
	end

	// row stores and item capture
	always_ff @(posedge clk) begin
		if (take) begin
			center_rd_q <= row1_mem[addr];
			right_rd_q  <= row1_mem[addr_right];
			up_rd_q     <= row2_mem[addr];
			down_q      <= e;
			drain_q     <= is_drain;
			last_q      <= !has_right;
			has_left_q  <= has_left;
			has_right_q <= has_right;
			has_up_q    <= is_drain ? (side >= ROW_W'(2)) : (y_q >= ROW_W'(2));
		end
		if (fire && !drain_q) begin
			row2_mem[addr] <= center_rd_q;
			row1_mem[addr] <= down_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			produce_q <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
			left_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg.restart) begin
						x_q    <= '0;
						y_q    <= '0;
						left_q <= '0;
					end
					if (take) begin
						produce_q <= is_drain || (y_q != '0);
						state_q   <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (fire) begin
						state_q <= S_IDLE;
						if (has_right) begin
							x_q    <= x_inc[COL_W-1:0];
							left_q <= center_rd_q;
						end else begin
							x_q    <= '0;
							left_q <= '0;
							y_q    <= drain_q ? '0 : (y_q + ROW_W'(1));
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_col_in_range, clk, arst_n, x_ext < side, "column count beyond image side")
	`ASSERT_NEXT(a_take_to_write, clk, arst_n, take, state_q == S_WRITE, "taken item lost")
endmodule

// ----- rtl/thfna_queue.sv -----
// Short job queue between front and back end.
// Depends on thfna_pkg.
`include "assert_macros.svh"

module thfna_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  thfna_pkg::job_t wr_data,
	input  logic            push,
	output logic            full,
	output thfna_pkg::job_t rd_data,
	output logic            empty,
	input  logic            pop
);
	import thfna_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	job_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full    = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(push && full), "push into full job queue")
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, !(pop && empty), "pop from empty job queue")
endmodule

// ----- rtl/thfna_back.sv -----
// Back end: sums the stencil, divides by the contributor count, forms the
// gray or color result and holds it in the output register. Depends on thfna_pkg.
module thfna_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            color,
	input  thfna_pkg::job_t job,
	input  logic            job_empty,
	output logic            job_pop,
	thfna_result_if.source  result
);
	import thfna_pkg::*;

	logic             en;
	logic             v_s1, v_s2, out_valid_q;
	logic [SUM_W-1:0] sum_r, sum_g, sum_b;
	logic [CNT_W-1:0] cnt;
	logic [SUM_W-1:0] sum_r_s1, sum_g_s1, sum_b_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             last_s1, fault_s1, last_s2, fault_s2;
	logic [SUM_W-1:0] q_r_s2, q_g_s2, q_b_s2, q_gray_s2, gray;
	logic [CH_W-1:0]  out_red_q, out_green_q, out_blue_q;
	logic             frame_last_q, fault_q;
	nbr_t             nbrs [4];

	// whole pipe moves together; it holds only while the result waits
	assign en      = !out_valid_q || result.ready;
	assign job_pop = en && !job_empty;

	assign nbrs[0] = job.left;
	assign nbrs[1] = job.right;
	assign nbrs[2] = job.up;
	assign nbrs[3] = job.down;

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		cnt   = '0;
		if (job.center.filled) begin
			sum_r = SUM_W'(job.center.rgb.r);
			sum_g = SUM_W'(job.center.rgb.g);
			sum_b = SUM_W'(job.center.rgb.b);
			cnt   = CNT_W'(1);
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (nbrs[i].valid) begin
					sum_r = sum_r + SUM_W'(nbrs[i].rgb.r);
					sum_g = sum_g + SUM_W'(nbrs[i].rgb.g);
					sum_b = sum_b + SUM_W'(nbrs[i].rgb.b);
					cnt   = cnt + CNT_W'(1);
				end
			end
		end
	end

	assign gray = div3(q_gray_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_r_s1    <= sum_r;
			sum_g_s1    <= sum_g;
			sum_b_s1    <= sum_b;
			cnt_s1      <= cnt;
			last_s1     <= job.last;
			fault_s1    <= job.center.fault;
			q_r_s2      <= div_n(sum_r_s1, cnt_s1);
			q_g_s2      <= div_n(sum_g_s1, cnt_s1);
			q_b_s2      <= div_n(sum_b_s1, cnt_s1);
			q_gray_s2   <= div_n(sum_r_s1 + sum_g_s1 + sum_b_s1, cnt_s1);
			last_s2     <= last_s1;
			fault_s2    <= fault_s1;
			out_red_q    <= color ? q_r_s2[CH_W-1:0] : gray[CH_W-1:0];
			out_green_q  <= color ? q_g_s2[CH_W-1:0] : '0;
			out_blue_q   <= color ? q_b_s2[CH_W-1:0] : '0;
			frame_last_q <= last_s2;
			fault_q      <= fault_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !job_empty;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_red    = out_red_q;
	assign result.out_green  = out_green_q;
	assign result.out_blue   = out_blue_q;
	assign result.frame_last = frame_last_q;
	assign result.fault      = fault_q;
endmodule
